// ===== hw/rtl/key_value_command_parser_defines.svh =====
// assertion macros used by the parser core rtl
`ifndef KEY_VALUE_COMMAND_PARSER_DEFINES_SVH
`define KEY_VALUE_COMMAND_PARSER_DEFINES_SVH

// condition holds in the same cycle
`define KVCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// condition holds in the next cycle
`define KVCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/kvcp_pkg.sv =====
`timescale 1ns / 1ps

package kvcp_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned KLEN_BITS  = 3;

  localparam logic [KLEN_BITS-1:0] KEY_TOO_LONG = 3'd5;
  localparam logic [KLEN_BITS-1:0] KEY_LEN_FOUR = 3'd4;
  localparam logic [KLEN_BITS-1:0] KEY_LEN_THREE = 3'd3;

  localparam logic [KEY_BITS-1:0] KEY_PUMP = 32'h5055_4D50;
  localparam logic [KEY_BITS-1:0] KEY_FAN  = 32'h0046_414E;
  localparam logic [KEY_BITS-1:0] KEY_LED  = 32'h004C_4544;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_PUMP  = 2'd1,
    UPD_FAN   = 2'd2,
    UPD_LIGHT = 2'd3
  } upd_e;

  typedef struct packed {
    logic [7:0] character;
    logic       message_end;
  } item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] pump_level;
    logic [LEVEL_BITS-1:0] fan_level;
    logic [LEVEL_BITS-1:0] light_level;
    upd_e                  updated_field;
  } res_t;

endpackage

// ===== hw/rtl/key_value_command_parser.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | character_i, message_end_i
// out     | output    | out_valid_o/out_stall_i | pump/fan/light_level_o, updated_field_o
// one request in per cycle while in_stall_o is low; its result passes the input
// register, then the result register, before it is offered, one result per request
// asynchronous active-low reset clears the key, value and command registers
// in_stall_o rises only when the input register is full and the result
// register is held by out_stall_i

module key_value_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  character_i,
  input  logic        message_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pump_level_o,
  output logic [15:0] fan_level_o,
  output logic [15:0] light_level_o,
  output logic [1:0]  updated_field_o
);
  import kvcp_pkg::*;

  item_t item_in, item_q;
  res_t  res_d, res_q;
  logic  adv, step;

  assign item_in.character   = character_i;
  assign item_in.message_end = message_end_i;

  kvcp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .adv_i      (adv),
    .step_o     (step),
    .item_o     (item_q)
  );

  kvcp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res_d)
  );

  kvcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .adv_o       (adv),
    .res_o       (res_q)
  );

  assign pump_level_o    = res_q.pump_level;
  assign fan_level_o     = res_q.fan_level;
  assign light_level_o   = res_q.light_level;
  assign updated_field_o = res_q.updated_field;

endmodule

// ===== hw/rtl/kvcp_in_reg.sv =====
`timescale 1ns / 1ps

module kvcp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kvcp_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           step_o,
  output kvcp_pkg::item_t item_o
);
  import kvcp_pkg::*;

  logic  vld_q, vld_d;
  logic  load;
  item_t item_q;

  assign in_stall_o = vld_q & ~adv_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign step_o     = vld_q & adv_i;
  assign item_o     = item_q;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (step_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== hw/rtl/kvcp_core.sv =====
`timescale 1ns / 1ps
`include "key_value_command_parser_defines.svh"

module kvcp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  kvcp_pkg::item_t item_i,
  output kvcp_pkg::res_t  res_o
);
  import kvcp_pkg::*;

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [KLEN_BITS-1:0]  klen_q, klen_d;
  logic [VALUE_BITS-1:0] dig_q, dig_d;
  logic [VALUE_BITS-1:0] pump_q, pump_d;
  logic [VALUE_BITS-1:0] fan_q, fan_d;
  logic [VALUE_BITS-1:0] light_q, light_d;
  logic [VALUE_BITS+3:0] tenx;
  logic [7:0]            ch;
  upd_e                  upd;

  assign ch   = item_i.character;
  // value * 10 + digit
  assign tenx = ({4'b0000, dig_q} << 3) + ({4'b0000, dig_q} << 1)
              + {{VALUE_BITS{1'b0}}, ch[3:0]};

  always_comb begin
    key_d   = key_q;
    klen_d  = klen_q;
    dig_d   = dig_q;
    pump_d  = pump_q;
    fan_d   = fan_q;
    light_d = light_q;
    upd     = UPD_NONE;
    priority if (ch == CH_LBRACE || ch == CH_SPACE || ch == CH_DQUOTE ||
                 ch == CH_SQUOTE || ch == CH_COLON) begin
      // dropped
    end else if (ch == CH_COMMA || ch == CH_RBRACE) begin
      if (klen_q == KEY_LEN_FOUR && key_q == KEY_PUMP) begin
        pump_d = dig_q;
        upd    = UPD_PUMP;
      end else if (klen_q == KEY_LEN_THREE && key_q == KEY_FAN) begin
        fan_d = dig_q;
        upd   = UPD_FAN;
      end else if (klen_q == KEY_LEN_THREE && key_q == KEY_LED) begin
        light_d = dig_q;
        upd     = UPD_LIGHT;
      end
      key_d  = '0;
      klen_d = '0;
      dig_d  = '0;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (tenx[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
        dig_d = '1;
      end else begin
        dig_d = tenx[VALUE_BITS-1:0];
      end
    end else if ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z)) begin
      key_d = {key_q[KEY_BITS-9:0], ch};
      if (klen_q < KEY_TOO_LONG) begin
        klen_d = klen_q + 3'd1;
      end
    end else begin
      // other bytes ignored
    end
    if (item_i.message_end) begin
      key_d  = '0;
      klen_d = '0;
      dig_d  = '0;
    end
  end

  assign res_o.pump_level    = LEVEL_BITS'(pump_d);
  assign res_o.fan_level     = LEVEL_BITS'(fan_d);
  assign res_o.light_level   = LEVEL_BITS'(light_d);
  assign res_o.updated_field = upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      klen_q  <= '0;
      dig_q   <= '0;
      pump_q  <= '0;
      fan_q   <= '0;
      light_q <= '0;
    end else if (step_i) begin
      key_q   <= key_d;
      klen_q  <= klen_d;
      dig_q   <= dig_d;
      pump_q  <= pump_d;
      fan_q   <= fan_d;
      light_q <= light_d;
    end
  end

  `KVCP_ASSERT_NOW(a_klen_range, clk_i, rst_ni, 1'b1, klen_q <= KEY_TOO_LONG)
  `KVCP_ASSERT_NEXT(a_pump_load, clk_i, rst_ni, step_i && upd == UPD_PUMP,
    pump_q == $past(dig_q))
  `KVCP_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, step_i && item_i.message_end,
    klen_q == '0 && dig_q == '0 && key_q == '0)
  `KVCP_ASSERT_NEXT(a_hold_idle, clk_i, rst_ni, !step_i,
    $stable(pump_q) && $stable(fan_q) && $stable(light_q) && $stable(dig_q))

endmodule

// ===== hw/rtl/kvcp_out_reg.sv =====
`timescale 1ns / 1ps

module kvcp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  kvcp_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           adv_o,
  output kvcp_pkg::res_t res_o
);
  import kvcp_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign adv_o       = ~vld_q | ~out_stall_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (vld_q && !out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== dv/tb_key_value_command_parser.sv =====
`timescale 1ns / 1ps

module tb_key_value_command_parser;
  import kvcp_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_TOP = '1;
  localparam int unsigned CHARS_PER_BURST = 140;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  character_i = 8'h00;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] pump_level_o;
  logic [15:0] fan_level_o;
  logic [15:0] light_level_o;
  logic [1:0]  updated_field_o;

  item_t chars_pending[$];
  res_t  levels_due[$];
  logic  in_fire = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned counted = 0;
  int unsigned errors = 0;

  // parser state mirror
  logic [KEY_BITS-1:0]   key_word = '0;
  logic [KLEN_BITS-1:0]  key_count = '0;
  logic [VALUE_BITS-1:0] value_acc = '0;
  logic [VALUE_BITS-1:0] pump_reg = '0;
  logic [VALUE_BITS-1:0] fan_reg = '0;
  logic [VALUE_BITS-1:0] light_reg = '0;

  key_value_command_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pump_level_o   (pump_level_o),
    .fan_level_o    (fan_level_o),
    .light_level_o  (light_level_o),
    .updated_field_o(updated_field_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit is_dropped(input logic [7:0] ch);
    return ch == CH_LBRACE || ch == CH_SPACE || ch == CH_DQUOTE || ch == CH_SQUOTE ||
           ch == CH_COLON;
  endfunction

  function automatic void drop_key_value();
    key_word = '0;
    key_count = '0;
    value_acc = '0;
  endfunction

  function automatic res_t parse_char(input logic [7:0] ch, input logic last);
    res_t r;
    longint unsigned acc;
    r.updated_field = UPD_NONE;
    if (is_dropped(ch)) begin
    end else if (ch == CH_COMMA || ch == CH_RBRACE) begin
      if (key_count == KEY_LEN_FOUR && key_word == KEY_PUMP) begin
        pump_reg = value_acc;
        r.updated_field = UPD_PUMP;
      end else if (key_count == KEY_LEN_THREE && key_word == KEY_FAN) begin
        fan_reg = value_acc;
        r.updated_field = UPD_FAN;
      end else if (key_count == KEY_LEN_THREE && key_word == KEY_LED) begin
        light_reg = value_acc;
        r.updated_field = UPD_LIGHT;
      end
      drop_key_value();
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      acc = 64'(value_acc) * 64'd10 + 64'(ch - CH_ZERO);
      value_acc = (acc > 64'(VALUE_TOP)) ? VALUE_TOP : acc[VALUE_BITS-1:0];
    end else if ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z)) begin
      key_word = {key_word[KEY_BITS-9:0], ch};
      if (key_count < KEY_TOO_LONG) key_count = key_count + 1'b1;
    end
    if (last) drop_key_value();
    r.pump_level  = pump_reg[LEVEL_BITS-1:0];
    r.fan_level   = fan_reg[LEVEL_BITS-1:0];
    r.light_level = light_reg[LEVEL_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(negedge clk_i) begin
    if (in_fire) void'(chars_pending.pop_front());
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i    <= 1'b1;
        character_i   <= chars_pending[0].character;
        message_end_i <= chars_pending[0].message_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // result side
  always @(posedge clk_i) begin
    res_t want;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (levels_due.size() == 0) begin
        $display("%0t: result with none outstanding, pump %0d fan %0d light %0d upd %0d",
                 $time, pump_level_o, fan_level_o, light_level_o, updated_field_o);
        errors++;
      end else begin
        want = levels_due.pop_front();
        check_field("pump_level", want.pump_level, pump_level_o);
        check_field("fan_level", want.fan_level, fan_level_o);
        check_field("light_level", want.light_level, light_level_o);
        check_field("updated_field", want.updated_field, updated_field_o);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      levels_due.push_back(parse_char(character_i, message_end_i));
  end

  task automatic push_char(input logic [7:0] ch, input logic last);
    item_t it;
    it.character = ch;
    it.message_end = last;
    chars_pending.push_back(it);
    counted++;
  endtask

  task automatic push_text(input string s, input bit last = 1'b0);
    for (int i = 0; i < s.len(); i++) push_char(s[i], last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(25));
  endfunction

  task automatic push_digits();
    int unsigned nd;
    case ($urandom_range(7))
      0: nd = 0;
      1: nd = 6;
      default: nd = $urandom_range(1, 5);
    endcase
    repeat (nd) push_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic push_key();
    case ($urandom_range(9))
      0, 1: push_text("PUMP");
      2, 3: push_text("FAN");
      4, 5: push_text("LED");
      6: begin
        case ($urandom_range(3))
          0: push_text("pump");
          1: push_text("fan");
          2: push_text("led");
          default: push_text("Fan");
        endcase
      end
      7: begin
        repeat ($urandom_range(1, 2)) push_char(rand_letter(), 1'b0);
        case ($urandom_range(2))
          0: push_text("PUMP");
          1: push_text("FAN");
          default: push_text("LED");
        endcase
      end
      default: repeat ($urandom_range(1, 6)) push_char(rand_letter(), 1'b0);
    endcase
  endtask

  task automatic push_message();
    int unsigned pairs;
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 12)) push_char(8'($urandom), $urandom_range(7) == 0);
    end else begin
      pairs = $urandom_range(1, 4);
      if ($urandom_range(3) != 0) push_char(CH_LBRACE, 1'b0);
      for (int p = 0; p < pairs; p++) begin
        if ($urandom_range(9) == 0) push_digits();
        if ($urandom_range(1)) push_char(CH_DQUOTE, 1'b0);
        push_key();
        if ($urandom_range(1)) push_char($urandom_range(1) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
        if ($urandom_range(7) != 0) push_char(CH_COLON, 1'b0);
        if ($urandom_range(3) == 0) push_char(CH_SPACE, 1'b0);
        push_digits();
        if ($urandom_range(15) == 0) push_char(8'($urandom), 1'b0);
        if (p != pairs - 1) push_char(CH_COMMA, 1'b0);
      end
      if ($urandom_range(7) == 0)
        push_char(CH_ZERO + 8'($urandom_range(9)), 1'b1);
      else
        push_char(CH_RBRACE, $urandom_range(7) != 0);
    end
  endtask

  task automatic wait_idle();
    while (chars_pending.size() != 0 || levels_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // saturating value with digits ahead of the key, empty value, long key
    push_text("6PUMP5536,");
    push_text("FAN}");
    push_text("aPUMP5,");
    push_text("{\"LED': 7");
    push_char(8'hFF, 1'b1);
    push_text("z}");
    push_char(8'h00, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      // sender holds back mid-phase until the pipe is empty
      repeat (2) begin
        counted = 0;
        while (counted < CHARS_PER_BURST) push_message();
        wait_idle();
      end
    end

    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
